@@ hdl/ptw_pkg.sv @@
// ---------------------------------------------------------------------------
// ptw_pkg
// Shared widths, codes, result type and granule tables of the page table walker.
// ---------------------------------------------------------------------------
package ptw_pkg;

	localparam int PA_BITS   = 47;
	localparam int VA_BITS   = 48;
	localparam int DATA_BITS = 64;
	localparam int SHIFT_W   = 6;
	localparam int IDXW_W    = 4;
	localparam int CFG_DW    = 3;

	// input function codes
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_RESP  = 1'b1;

	// result kinds
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// configuration register indexes
	localparam logic CFG_GRANULE = 1'b0;
	localparam logic CFG_LEVELS  = 1'b1;

	// granule codes
	localparam logic [1:0] GRAN_4K  = 2'd0;
	localparam logic [1:0] GRAN_16K = 2'd1;
	localparam logic [1:0] GRAN_64K = 2'd2;
	localparam logic [1:0] GRAN_RSV = 2'd3;

	localparam logic [1:0] DESC_BLOCK   = 2'b01;
	localparam logic [1:0] LAST_LEVEL   = 2'd3;
	localparam logic [2:0] LEVELS_RESET = 3'd4;
	localparam logic [VA_BITS-1:0] ROOT_OFFSET = VA_BITS'(8);

	typedef struct packed {
		logic                 kind;
		logic [VA_BITS-1:0]   read_addr;
		logic [PA_BITS-1:0]   phys_addr;
		logic [SHIFT_W-1:0]   map_shift;
		logic                 fault;
	} ptw_res_t;

	// address bit where the index of a level starts
	function automatic logic [SHIFT_W-1:0] lvl_shift(logic [1:0] g, logic [1:0] l);
		logic [SHIFT_W-1:0] s;
		unique case ({g, l})
			{GRAN_4K,  2'd0}: s = 6'd39;
			{GRAN_4K,  2'd1}: s = 6'd30;
			{GRAN_4K,  2'd2}: s = 6'd21;
			{GRAN_4K,  2'd3}: s = 6'd12;
			{GRAN_16K, 2'd0}: s = 6'd47;
			{GRAN_16K, 2'd1}: s = 6'd36;
			{GRAN_16K, 2'd2}: s = 6'd25;
			{GRAN_16K, 2'd3}: s = 6'd14;
			{GRAN_64K, 2'd0}: s = 6'd0;
			{GRAN_64K, 2'd1}: s = 6'd42;
			{GRAN_64K, 2'd2}: s = 6'd29;
			{GRAN_64K, 2'd3}: s = 6'd16;
			default:          s = 6'd0;
		endcase
		return s;
	endfunction

	// number of index bits at a level
	function automatic logic [IDXW_W-1:0] idx_width(logic [1:0] g, logic [1:0] l);
		logic [IDXW_W-1:0] w;
		unique case (g)
			GRAN_4K:  w = 4'd9;
			GRAN_16K: w = (l == 2'd0) ? 4'd1 : 4'd11;
			GRAN_64K: begin
				unique case (l)
					2'd0:    w = 4'd0;
					2'd1:    w = 4'd6;
					default: w = 4'd13;
				endcase
			end
			default:  w = 4'd0;
		endcase
		return w;
	endfunction

	// levels that may hold a block descriptor
	function automatic logic blk_ok(logic [1:0] g, logic [1:0] l);
		logic ok;
		unique case (g)
			GRAN_4K: ok = (l == 2'd1) || (l == 2'd2);
			default: ok = (l == 2'd2);
		endcase
		return ok;
	endfunction

	function automatic logic [VA_BITS-1:0] low_mask(logic [SHIFT_W-1:0] s);
		return (VA_BITS'(1) << s) - VA_BITS'(1);
	endfunction

endpackage

@@ hdl/ptw_in_if.sv @@
// ---------------------------------------------------------------------------
// ptw_in_if
// Input channel: start transactions and memory read responses.
// ---------------------------------------------------------------------------
interface ptw_in_if import ptw_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [VA_BITS-1:0]   virt_addr;
	logic [PA_BITS-1:0]   root_record_addr;
	logic [DATA_BITS-1:0] read_data;

	modport source (output valid, func, virt_addr, root_record_addr, read_data,
		input ready);
	modport sink (input valid, func, virt_addr, root_record_addr, read_data,
		output ready);
endinterface

@@ hdl/ptw_out_if.sv @@
// ---------------------------------------------------------------------------
// ptw_out_if
// Output channel: read requests and finished translations.
// ---------------------------------------------------------------------------
interface ptw_out_if import ptw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               kind;
	logic [VA_BITS-1:0] read_addr;
	logic [PA_BITS-1:0] phys_addr;
	logic [SHIFT_W-1:0] map_shift;
	logic               fault;

	modport source (output valid, kind, read_addr, phys_addr, map_shift, fault,
		input ready);
	modport sink (input valid, kind, read_addr, phys_addr, map_shift, fault,
		output ready);
endinterface

@@ hdl/ptw_core.sv @@
// ---------------------------------------------------------------------------
// ptw_core
// Input register, walk state and one-pass step logic of the walker.
// ---------------------------------------------------------------------------
module ptw_core import ptw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [CFG_DW-1:0] cfg_data,
	ptw_in_if.sink            in_ch,
	input  logic              buf_full,
	output logic              res_push,
	output ptw_res_t          res
);

	logic [1:0]           granule_q;
	logic [2:0]           levels_q;

	logic                 valid_s1;
	logic                 func_s1;
	logic [VA_BITS-1:0]   va_s1;
	logic [PA_BITS-1:0]   rra_s1;
	logic [DATA_BITS-1:0] data_s1;

	logic                 busy_q, fetch_root_q;
	logic [1:0]           walk_level_q;
	logic [VA_BITS-1:0]   held_va_q;

	logic                 busy_d, fetch_root_d;
	logic [1:0]           walk_level_d;
	logic                 adv, accept;

	logic [1:0]           gsel, first_lvl, req_l;
	logic [2:0]           nlev;
	logic [VA_BITS-1:0]   dm, gmask, bmask, tb_desc, req_tb, ix, req_addr;
	logic [SHIFT_W-1:0]   gshift, bshift;

	assign adv         = !buf_full;
	assign in_ch.ready = !valid_s1 || adv;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			granule_q <= GRAN_4K;
			levels_q  <= LEVELS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_GRANULE: granule_q <= cfg_data[1:0];
				CFG_LEVELS:  levels_q  <= cfg_data;
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= in_ch.func;
			va_s1   <= in_ch.virt_addr;
			rra_s1  <= in_ch.root_record_addr;
			data_s1 <= in_ch.read_data;
		end
	end

	always_comb begin
		gsel = (granule_q == GRAN_RSV) ? GRAN_4K : granule_q;
		nlev = levels_q;
		if (nlev == 3'd0)
			nlev = 3'd1;
		if (nlev > 3'd4)
			nlev = 3'd4;
		if (gsel == GRAN_64K && nlev > 3'd3)
			nlev = 3'd3;
		first_lvl = 2'(3'd4 - nlev);
	end

	always_comb begin
		dm      = VA_BITS'(data_s1[PA_BITS-1:0]);
		gshift  = lvl_shift(gsel, LAST_LEVEL);
		gmask   = low_mask(gshift);
		bshift  = lvl_shift(gsel, walk_level_q);
		bmask   = low_mask(bshift);
		tb_desc = dm & ~gmask;
		// the root record word is used unaligned
		req_tb  = fetch_root_q ? dm : tb_desc;
		req_l   = fetch_root_q ? first_lvl : walk_level_q + 2'd1;
		ix      = (held_va_q >> lvl_shift(gsel, req_l)) &
			low_mask(SHIFT_W'(idx_width(gsel, req_l)));
		req_addr = req_tb + (ix << 3);
	end

	always_comb begin
		busy_d       = busy_q;
		fetch_root_d = fetch_root_q;
		walk_level_d = walk_level_q;
		res_push     = 1'b0;
		res          = '0;
		if (valid_s1 && adv) begin
			if (func_s1 == FUNC_START) begin
				busy_d        = 1'b1;
				fetch_root_d  = 1'b1;
				walk_level_d  = 2'd0;
				res_push      = 1'b1;
				res.kind      = KIND_READ;
				res.read_addr = VA_BITS'(rra_s1) + ROOT_OFFSET;
			end else if (busy_q) begin
				res_push = 1'b1;
				priority if (fetch_root_q) begin
					fetch_root_d  = 1'b0;
					walk_level_d  = first_lvl;
					res.kind      = KIND_READ;
					res.read_addr = req_addr;
				end else if (!data_s1[0]) begin
					busy_d    = 1'b0;
					res.kind  = KIND_DONE;
					res.fault = 1'b1;
				end else if (blk_ok(gsel, walk_level_q) && data_s1[1:0] == DESC_BLOCK) begin
					busy_d         = 1'b0;
					res.kind       = KIND_DONE;
					res.phys_addr  = PA_BITS'((dm & ~bmask) | (held_va_q & bmask));
					res.map_shift  = bshift;
				end else if (walk_level_q == LAST_LEVEL) begin
					busy_d         = 1'b0;
					res.kind       = KIND_DONE;
					res.phys_addr  = PA_BITS'(tb_desc | (held_va_q & gmask));
					res.map_shift  = gshift;
				end else begin
					walk_level_d  = req_l;
					res.kind      = KIND_READ;
					res.read_addr = req_addr;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			fetch_root_q <= 1'b0;
			walk_level_q <= 2'd0;
			held_va_q    <= '0;
		end else begin
			busy_q       <= busy_d;
			fetch_root_q <= fetch_root_d;
			walk_level_q <= walk_level_d;
			if (valid_s1 && adv && func_s1 == FUNC_START)
				held_va_q <= va_s1;
		end
	end

	a_root_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_root_q |-> busy_q)
		else $error("root fetch pending while idle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.kind == KIND_DONE) |=> !busy_q)
		else $error("walk still busy after finishing");

	a_start_root: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv && func_s1 == FUNC_START) |=> (busy_q && fetch_root_q))
		else $error("start did not arm root fetch");

	a_push_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !buf_full)
		else $error("result pushed into full buffer");

endmodule

@@ hdl/ptw_obuf.sv @@
// ---------------------------------------------------------------------------
// ptw_obuf
// Two-entry result buffer that decouples the step logic from output stalls.
// ---------------------------------------------------------------------------
module ptw_obuf import ptw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  ptw_res_t push_data,
	output logic     full,
	ptw_out_if.source out_ch
);

	ptw_res_t   ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;
	ptw_res_t   head;

	assign full         = (cnt_q == 2'd2);
	assign pop          = out_ch.valid && out_ch.ready;
	assign head         = ent_q[rd_ptr_q];
	assign out_ch.valid = (cnt_q != 2'd0);
	assign out_ch.kind       = head.kind;
	assign out_ch.read_addr  = head.read_addr;
	assign out_ch.phys_addr  = head.phys_addr;
	assign out_ch.map_shift  = head.map_shift;
	assign out_ch.fault      = head.fault;

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result buffer count overflow");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		((cnt_q == 2'd0) || (cnt_q == 2'd2)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("result buffer pointers out of step");

endmodule

@@ hdl/page_table_walker_top.sv @@
// ---------------------------------------------------------------------------
// page_table_walker_top
// Multi-level page table walker for 4KB/16KB/64KB granules.
//
//   channel  dir  payload                                        handshake
//   in_ch    in   func, virt_addr, root_record_addr, read_data   valid/ready
//   out_ch   out  kind, read_addr, phys_addr, map_shift, fault   valid/ready
//   cfg      in   cfg_idx (0 granule, 1 levels), cfg_data        cfg_we
//
// One transaction per cycle is taken while the result buffer is not full; each
// result passes the input register, then step logic into the result buffer.
// A response while idle yields no result. Reset clears the walk state and
// sets granule 4KB, four levels. When the two-entry result buffer is full
// the input register holds its transaction and in_ch.ready stays low while
// that register is occupied.
// ---------------------------------------------------------------------------
module page_table_walker_top import ptw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [CFG_DW-1:0] cfg_data,
	ptw_in_if.sink            in_ch,
	ptw_out_if.source         out_ch
);

	logic     buf_full;
	logic     res_push;
	ptw_res_t res;

	ptw_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.buf_full (buf_full),
		.res_push (res_push),
		.res      (res)
	);

	ptw_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.full      (buf_full),
		.out_ch    (out_ch)
	);

endmodule

@@ tb/tb_page_table_walker_top.sv @@
// ---------------------------------------------------------------------------
// tb_page_table_walker_top
// Self-checking bench for the page table walker. Drives start and memory
// response transactions under random valid/ready gaps, predicts each read
// request and finished translation, and compares every result field by field.
// ---------------------------------------------------------------------------
module tb_page_table_walker_top;
	import ptw_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 80;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_COUNT = 14;
	localparam int PHASE_RESULTS = 110;
	localparam int MAX_REPORTS = 40;

	localparam logic [63:0] PA_MASK = (64'd1 << PA_BITS) - 64'd1;
	localparam logic [1:0] DESC_TABLE = 2'b11;

	// per granule and level: index start bit, index width, block allowed
	localparam int unsigned LVL_SHIFT [3][4] = '{'{39, 30, 21, 12}, '{47, 36, 25, 14},
		'{0, 42, 29, 16}};
	localparam int unsigned LVL_WIDTH [3][4] = '{'{9, 9, 9, 9}, '{1, 11, 11, 11},
		'{0, 6, 13, 13}};
	localparam bit LVL_BLOCK [3][4] = '{'{0, 1, 1, 0}, '{0, 0, 1, 0}, '{0, 0, 1, 0}};

	// granule and level count of each phase; reserved and out-of-range values included
	localparam logic [1:0] PHASE_GRAN [PHASE_COUNT] = '{GRAN_4K, GRAN_4K, GRAN_16K, GRAN_64K,
		GRAN_64K, GRAN_16K, GRAN_4K, GRAN_RSV, GRAN_64K, GRAN_4K, GRAN_16K, GRAN_64K,
		GRAN_4K, GRAN_16K};
	localparam logic [2:0] PHASE_LVLS [PHASE_COUNT] = '{3'd4, 3'd3, 3'd4, 3'd3, 3'd4, 3'd1,
		3'd1, 3'd2, 3'd7, 3'd0, 3'd3, 3'd1, 3'd2, 3'd2};

	typedef struct packed {
		logic                 func;
		logic [VA_BITS-1:0]   virt_addr;
		logic [PA_BITS-1:0]   root_record_addr;
		logic [DATA_BITS-1:0] read_data;
	} walk_item_t;

	class walk_scoreboard;
		logic [1:0] granule;
		logic [2:0] levels;
		bit walk_busy;
		bit root_pending;
		logic [1:0] cur_level;
		logic [VA_BITS-1:0] held_va;
		logic [PA_BITS-1:0] table_base;
		ptw_res_t due_results[$];
		int mismatches;
		int checked;
		int faults;
		int blocks;
		int pages;

		function new();
			granule = GRAN_4K;
			levels = LEVELS_RESET;
			walk_busy = 0;
			root_pending = 0;
			cur_level = '0;
			held_va = '0;
			table_base = '0;
		endfunction

		function void write_reg(logic idx, logic [CFG_DW-1:0] val);
			if (idx == CFG_GRANULE) begin
				granule = val[1:0];
			end else begin
				levels = val;
			end
		endfunction

		function logic [1:0] eff_granule();
			return (granule == GRAN_RSV) ? GRAN_4K : granule;
		endfunction

		function logic [1:0] top_level();
			int n;
			n = levels;
			if (n < 1) n = 1;
			if (n > 4) n = 4;
			if (eff_granule() == GRAN_64K && n > 3) n = 3;
			return 2'(4 - n);
		endfunction

		function ptw_res_t read_request(logic [VA_BITS-1:0] addr);
			ptw_res_t r;
			r = '0;
			r.kind = KIND_READ;
			r.read_addr = addr;
			return r;
		endfunction

		function ptw_res_t desc_request();
			logic [1:0] g;
			logic [63:0] ix;
			g = eff_granule();
			ix = (64'(held_va) >> LVL_SHIFT[g][cur_level]) &
				((64'd1 << LVL_WIDTH[g][cur_level]) - 64'd1);
			return read_request(VA_BITS'(64'(table_base) + (ix << 3)));
		endfunction

		// returns 1 when the transaction produces a result
		function bit note_transaction(walk_item_t it);
			ptw_res_t r;
			logic [1:0] g;
			logic [63:0] d;
			logic [63:0] gmask;
			logic [63:0] bmask;
			logic [63:0] pa;
			int unsigned gsh;
			int unsigned bsh;
			g = eff_granule();
			if (it.func == FUNC_START) begin
				held_va = it.virt_addr;
				walk_busy = 1;
				root_pending = 1;
				cur_level = '0;
				due_results.push_back(read_request(VA_BITS'(it.root_record_addr) + ROOT_OFFSET));
				return 1;
			end
			if (!walk_busy) return 0;
			d = it.read_data;
			if (root_pending) begin
				root_pending = 0;
				table_base = d[PA_BITS-1:0];
				cur_level = top_level();
				due_results.push_back(desc_request());
				return 1;
			end
			gsh = LVL_SHIFT[g][LAST_LEVEL];
			gmask = (64'd1 << gsh) - 64'd1;
			r = '0;
			r.kind = KIND_DONE;
			if (!d[0]) begin
				walk_busy = 0;
				r.fault = 1'b1;
				faults++;
			end else if (LVL_BLOCK[g][cur_level] && d[1:0] == DESC_BLOCK) begin
				bsh = LVL_SHIFT[g][cur_level];
				bmask = (64'd1 << bsh) - 64'd1;
				pa = ((d & PA_MASK) & ~bmask) | (64'(held_va) & bmask);
				walk_busy = 0;
				r.phys_addr = pa[PA_BITS-1:0];
				r.map_shift = SHIFT_W'(bsh);
				blocks++;
			end else begin
				table_base = PA_BITS'((d & PA_MASK) & ~gmask);
				if (cur_level == LAST_LEVEL) begin
					pa = 64'(table_base) | (64'(held_va) & gmask);
					walk_busy = 0;
					r.phys_addr = pa[PA_BITS-1:0];
					r.map_shift = SHIFT_W'(gsh);
					pages++;
				end else begin
					cur_level = cur_level + 2'd1;
					r = desc_request();
				end
			end
			due_results.push_back(r);
			return 1;
		endfunction

		task report_mismatch(string what);
			if (mismatches < MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		task check_result(ptw_res_t got);
			ptw_res_t want;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: %h", got));
				return;
			end
			want = due_results.pop_front();
			checked++;
			if (got.kind !== want.kind)
				report_mismatch($sformatf("kind %h, want %h", got.kind, want.kind));
			if (got.read_addr !== want.read_addr)
				report_mismatch($sformatf("read_addr %h, want %h", got.read_addr, want.read_addr));
			if (got.phys_addr !== want.phys_addr)
				report_mismatch($sformatf("phys_addr %h, want %h", got.phys_addr, want.phys_addr));
			if (got.map_shift !== want.map_shift)
				report_mismatch($sformatf("map_shift %0d, want %0d", got.map_shift,
					want.map_shift));
			if (got.fault !== want.fault)
				report_mismatch($sformatf("fault %b, want %b", got.fault, want.fault));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_idx;
	logic [CFG_DW-1:0] cfg_data;

	ptw_in_if in_ch();
	ptw_out_if out_ch();

	page_table_walker_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	walk_scoreboard sb = new();

	bit steady = 0;
	bit hold_req = 0;
	int cycle_cnt = 0;
	int results_sent = 0;
	int ignored_cnt = 0;
	int config_cnt = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: random back-pressure, plus one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end else begin
				out_ch.ready <= steady || ($urandom_range(99) >= 34);
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		ptw_res_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.kind = out_ch.kind;
			got.read_addr = out_ch.read_addr;
			got.phys_addr = out_ch.phys_addr;
			got.map_shift = out_ch.map_shift;
			got.fault = out_ch.fault;
			sb.check_result(got);
		end
	end

	task automatic send_item(walk_item_t it);
		while (!steady && $urandom_range(99) < 34) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= it.func;
		in_ch.virt_addr <= it.virt_addr;
		in_ch.root_record_addr <= it.root_record_addr;
		in_ch.read_data <= it.read_data;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		if (sb.note_transaction(it)) results_sent++;
		else ignored_cnt++;
	endtask

	task automatic send_start(logic [VA_BITS-1:0] va, logic [PA_BITS-1:0] root);
		walk_item_t it;
		it.func = FUNC_START;
		it.virt_addr = va;
		it.root_record_addr = root;
		it.read_data = {$urandom, $urandom};
		send_item(it);
	endtask

	task automatic send_resp(logic [DATA_BITS-1:0] d);
		walk_item_t it;
		it.func = FUNC_RESP;
		it.virt_addr = VA_BITS'({$urandom, $urandom});
		it.root_record_addr = PA_BITS'({$urandom, $urandom});
		it.read_data = d;
		send_item(it);
	endtask

	function automatic logic [DATA_BITS-1:0] make_desc();
		logic [DATA_BITS-1:0] d;
		int p;
		d = {$urandom, $urandom};
		p = $urandom_range(99);
		if (p < 10) d[0] = 1'b0;
		else if (p < 30) d[1:0] = DESC_BLOCK;
		else if (p < 95) d[1:0] = DESC_TABLE;
		return d;
	endfunction

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_DW-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic set_config(logic [1:0] g, logic [2:0] lv);
		wait_drained();
		// bit 2 of the granule write is don't-care, toggle it anyway
		write_reg(CFG_GRANULE, {1'($urandom_range(1)), g});
		write_reg(CFG_LEVELS, lv);
		cfg_we <= 1'b0;
		config_cnt++;
	endtask

	// mostly complete walks with random content; a few drops and stray responses
	task automatic run_walks(int count);
		int target;
		int p;
		target = results_sent + count;
		while (results_sent < target) begin
			p = $urandom_range(99);
			if (!sb.walk_busy && p < 6)
				send_resp({$urandom, $urandom});
			else if (!sb.walk_busy || p < 3)
				send_start(VA_BITS'({$urandom, $urandom}), PA_BITS'({$urandom, $urandom}));
			else if (sb.root_pending)
				send_resp({$urandom, $urandom});
			else
				send_resp(make_desc());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_GRANULE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.func = FUNC_START;
		in_ch.virt_addr = '0;
		in_ch.root_record_addr = '0;
		in_ch.read_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: 4KB granule, walk starts at level 0
		send_resp('1);
		send_start('1, '1);
		send_resp('1);
		send_resp('1);
		send_resp(64'hFFFF_FFFF_FFFF_FFFD);
		send_start('0, '0);
		send_resp('0);
		send_resp(64'h3);
		send_resp(64'h3);
		send_resp(64'h1);
		// block pattern where blocks are not allowed: table at level 0, page at level 3
		send_start(VA_BITS'({$urandom, $urandom}), PA_BITS'({$urandom, $urandom}));
		send_resp({$urandom, $urandom});
		send_resp({$urandom, $urandom} & ~64'h2 | 64'h1);
		send_resp({$urandom, $urandom} | 64'h3);
		send_resp({$urandom, $urandom} | 64'h3);
		send_resp({$urandom, $urandom} & ~64'h2 | 64'h1);
		send_start(VA_BITS'({$urandom, $urandom}), PA_BITS'({$urandom, $urandom}));
		send_resp({$urandom, $urandom});
		send_resp(64'hFFFF_FFFF_FFFF_FFFE);
		// restart a walk that is still in progress
		send_start(VA_BITS'({$urandom, $urandom}), PA_BITS'({$urandom, $urandom}));
		send_resp({$urandom, $urandom});
		send_start(VA_BITS'({$urandom, $urandom}), PA_BITS'({$urandom, $urandom}));
		send_resp({$urandom, $urandom});
		send_resp('0);

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			set_config(PHASE_GRAN[ph], PHASE_LVLS[ph]);
			steady = (ph == 3);
			if (ph == 6) hold_req = 1;
			if (ph == 10) begin
				run_walks(PHASE_RESULTS / 2);
				wait_drained();
				run_walks(PHASE_RESULTS - PHASE_RESULTS / 2);
			end else begin
				run_walks(PHASE_RESULTS);
			end
		end
		steady = 0;

		wait_drained();
		$display("covered %0d results over %0d configurations: %0d faults, %0d blocks, %0d pages",
			sb.checked, config_cnt, sb.faults, sb.blocks, sb.pages);
		$display("plus %0d stray responses, restarts mid-walk and a long output hold-off",
			ignored_cnt);
		if (sb.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
